FILE: rtl/ptd_pkg.sv
package ptd_pkg;

	// Status from the serial remainder unit back to the controller
	typedef struct packed {
		logic done;
		logic zero;
	} rem_stat_t;

	localparam int unsigned FirstOddDiv = 3;

endpackage

FILE: rtl/ptd_rem.sv
module ptd_rem import ptd_pkg::*; #(
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned DIV_WIDTH  = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DIV_WIDTH-1:0]  divisor,
	output rem_stat_t             stat
);

	localparam int unsigned CntW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

	logic [DATA_WIDTH-1:0] sh_q;
	logic [DIV_WIDTH-1:0]  rem_q;
	logic [CntW-1:0]       cnt_q;
	logic                  run_q;
	logic                  done_q;
	logic                  zero_q;

	logic [DIV_WIDTH:0]    trial;
	logic [DIV_WIDTH:0]    diff;
	logic                  ge;
	logic [DIV_WIDTH-1:0]  rem_nxt;

	// Restoring step: bring in the next dividend bit, subtract if it fits
	always_comb begin
		trial   = {rem_q, sh_q[DATA_WIDTH-1]};
		diff    = trial - {1'b0, divisor};
		ge      = trial >= {1'b0, divisor};
		rem_nxt = ge ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= CntW'(DATA_WIDTH - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q  <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			sh_q  <= {sh_q[DATA_WIDTH-2:0], 1'b0};
			rem_q <= rem_nxt;
			if (cnt_q == '0)
				zero_q <= (rem_nxt == '0);
		end
	end

	assign stat.done = done_q;
	assign stat.zero = zero_q;

endmodule

FILE: rtl/ptd_cand.sv
module ptd_cand import ptd_pkg::*; #(
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned DIV_WIDTH  = 17
) (
	input  logic                  clk,
	input  logic                  init,
	input  logic                  step,
	input  logic [DATA_WIDTH-1:0] n,
	output logic [DIV_WIDTH-1:0]  divisor,
	output logic                  over
);

	localparam int unsigned SqW = DATA_WIDTH + 1;

	logic [DIV_WIDTH-1:0] d_q;
	logic [SqW-1:0]       sq_q;

	// Keep d*d alongside d: (d+2)^2 = d^2 + 4d + 4
	always_ff @(posedge clk) begin
		if (init) begin
			d_q  <= DIV_WIDTH'(FirstOddDiv);
			sq_q <= SqW'(FirstOddDiv * FirstOddDiv);
		end else if (step) begin
			d_q  <= d_q + DIV_WIDTH'(2);
			sq_q <= sq_q + SqW'({d_q, 2'b00}) + SqW'(4);
		end
	end

	assign divisor = d_q;
	assign over    = sq_q > {1'b0, n};

endmodule

FILE: rtl/prime_trial_division.sv
// Negative, zero, one, two and even values: done rises in the cycle after start is taken.
// Odd values above two try odd divisors d = 3, 5, ... until d*d passes the value or a
// factor ends the search (remainder zero).
// Per divisor: step state, serial remainder shifts, then a read of the remainder in S_DIV.
// One item at a time: busy is low while done is high, so the next transaction may enter then.
// Result on is_prime with done high for one cycle; the receiver cannot stall.
// arst_n clears the controller asynchronously; the block comes up idle.
module prime_trial_division import ptd_pkg::*; #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] value_in,
	output logic                         done,
	output logic                         is_prime
);

	localparam int unsigned DivW = DATA_WIDTH / 2 + 1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_STEP = 3'b010,
		S_DIV  = 3'b100
	} state_t;

	state_t               state_q;
	logic [DATA_WIDTH-1:0] n_q;
	logic                  done_q;
	logic                  prime_q;

	logic                  accept;
	logic                  v_neg;
	logic                  v_le1;
	logic                  v_two;
	logic                  v_even;
	logic                  cand_init;
	logic                  cand_step;
	logic                  rem_load;
	logic [DivW-1:0]       divisor;
	logic                  over;
	rem_stat_t             rem_stat;

	assign accept = start && (state_q == S_IDLE);
	assign v_neg  = value_in[DATA_WIDTH-1];
	assign v_le1  = (value_in[DATA_WIDTH-1:1] == '0);
	assign v_two  = (value_in[DATA_WIDTH-1:2] == '0) && (value_in[1:0] == 2'b10);
	assign v_even = !value_in[0];

	assign cand_init = accept && !v_neg && !v_le1 && !v_even;
	assign rem_load  = (state_q == S_STEP) && !over;
	assign cand_step = (state_q == S_DIV) && rem_stat.done && !rem_stat.zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cand_init)
							state_q <= S_STEP;
						else
							done_q <= 1'b1;
					end
				end
				S_STEP: begin
					if (over) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (rem_stat.done) begin
						if (rem_stat.zero) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_STEP;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q     <= value_in;
			prime_q <= !v_neg && (v_two || (!v_le1 && !v_even));
		end else if (state_q == S_DIV && rem_stat.done && rem_stat.zero) begin
			prime_q <= 1'b0;
		end
	end

	ptd_cand #(
		.DATA_WIDTH(DATA_WIDTH),
		.DIV_WIDTH (DivW)
	) u_cand (
		.clk    (clk),
		.init   (cand_init),
		.step   (cand_step),
		.n      (n_q),
		.divisor(divisor),
		.over   (over)
	);

	ptd_rem #(
		.DATA_WIDTH(DATA_WIDTH),
		.DIV_WIDTH (DivW)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (rem_load),
		.dividend(n_q),
		.divisor (divisor),
		.stat    (rem_stat)
	);

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign is_prime = prime_q;

endmodule

FILE: rtl/ptd_checker.sv
module ptd_checker #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic signed [DATA_WIDTH-1:0] value_in,
	input logic                         done,
	input logic                         is_prime
);

	// A negative value answers at once, not prime
	a_neg: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && value_in[DATA_WIDTH-1] |=> done && !is_prime)
		else $error("negative value not rejected in one cycle");

	a_two: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (value_in[DATA_WIDTH-1:2] == '0) && value_in[1] && !value_in[0]
		|=> done && is_prime)
		else $error("two not reported prime");

	a_even: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !value_in[DATA_WIDTH-1] && !value_in[0]
		&& (value_in[DATA_WIDTH-2:2] != '0) |=> done && !is_prime)
		else $error("even value above two not rejected");

	// A result closes the transaction: the block is idle while it shows
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without an accepted transaction");

endmodule

bind prime_trial_division ptd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_ptd_checker (.*);

FILE: tb/tb.sv
module tb;
	import ptd_pkg::*;

	localparam int unsigned W = 32;
	localparam int unsigned TRIAL_CAP = 256;
	localparam int unsigned RANDOM_ITEMS = 100;
	localparam int unsigned SETTLE_CYCLES = 64;

	// Boundaries: tiny values, squares of primes, the largest prime, signed extremes
	localparam logic [W-1:0] CORNER_VALUES [22] = '{
		32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49, 32'd97,
		32'd121, 32'd63001, 32'd65521, 32'd1042441, 32'h4000_0001,
		32'h7FFF_FFFD, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000,
		32'h8000_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic signed [W-1:0] value_in = '0;
	logic                busy;
	logic                done;
	logic                is_prime;

	logic [W-1:0] pending_values [$];
	logic         expected_verdicts [$];
	logic         took_item = 1'b0;
	int unsigned  mismatches = 0;
	int unsigned  burst_left = 0;
	int unsigned  gap_left = 0;

	prime_trial_division #(.DATA_WIDTH(W)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.value_in (value_in),
		.done     (done),
		.is_prime (is_prime)
	);

	always #5 clk = ~clk;

	// Verdict for one value; trials counts the odd divisors tried
	function automatic logic predict_prime(input logic [W-1:0] v, output int unsigned trials);
		longint unsigned n;
		longint unsigned d;
		trials = 0;
		n = v;
		if (v[W-1])
			return 1'b0;
		if (n <= 1)
			return 1'b0;
		if (n != 2 && n[0] == 1'b0)
			return 1'b0;
		for (d = FirstOddDiv; d <= n / d; d += 2) begin
			trials++;
			if (n % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [W-1:0] random_value();
		logic [W-1:0] v;
		int unsigned  trials;
		int unsigned  pick;
		pick = $urandom_range(0, 9);
		if (pick <= 3) begin
			v = $urandom_range(0, 1023);
		end else if (pick <= 5) begin
			v = $urandom_range(1024, 262143);
		end else if (pick <= 7) begin
			v = $urandom();
			// keep full-range values cheap: drop bit 0 if the search would run long
			void'(predict_prime(v, trials));
			if (trials > TRIAL_CAP)
				v[0] = 1'b0;
		end else if (pick == 8) begin
			v = $urandom() | 32'h8000_0000;
		end else begin
			v = $urandom_range(3, 511) * $urandom_range(3, 511);
		end
		return v;
	endfunction

	// Driver: present items on the falling edge, hold until taken
	always @(negedge clk) begin
		logic                nxt_start;
		logic signed [W-1:0] nxt_val;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			nxt_start = start;
			nxt_val = value_in;
			if (start && took_item) begin
				void'(pending_values.pop_front());
				nxt_start = 1'b0;
			end
			if (!nxt_start) begin
				nxt_val = $urandom();
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_values.size() != 0) begin
					nxt_start = 1'b1;
					nxt_val = pending_values[0];
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(0, 8);
						gap_left = $urandom_range(0, 12);
					end
				end
			end
			start <= nxt_start;
			value_in <= nxt_val;
		end
	end

	// Monitor: record each transaction, check each result strobe
	always @(posedge clk) begin
		int unsigned trials;
		logic        want;
		if (!arst_n) begin
			took_item = 1'b0;
		end else begin
			took_item = start && !busy;
			if (took_item)
				expected_verdicts.push_back(predict_prime(value_in, trials));
			if (done === 1'b1) begin
				if (expected_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with none pending, is_prime=%b", $realtime, is_prime);
				end else begin
					want = expected_verdicts.pop_front();
					if (is_prime !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: is_prime mismatch: expected %b, got %b",
								$realtime, want, is_prime);
					end
				end
			end
		end
	end

	initial begin
		foreach (CORNER_VALUES[i])
			pending_values.push_back(CORNER_VALUES[i]);
		repeat (RANDOM_ITEMS)
			pending_values.push_back(random_value());
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (pending_values.size() != 0 || expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#80_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/ptd_pkg.sv
rtl/ptd_rem.sv
rtl/ptd_cand.sv
rtl/prime_trial_division.sv
rtl/ptd_checker.sv
tb/tb.sv
